[rtl/core/gdt_pkg.sv]
// Shared types, constants and helper functions for the graph traversal block.
// Used by every file under rtl/core but gdt_ram; has no dependencies of its own.
package gdt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);

    typedef logic [VW-1:0]           vtx_t;
    typedef logic [AW-1:0]           addr_t;
    typedef logic [MAX_VERTICES-1:0] row_t;

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_DFS   = 2'd1,
        REQ_BFS   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_DFS_RD,
        ST_DFS_ROW,
        ST_DFS_PICK,
        ST_BFS_RD,
        ST_BFS_ROW,
        ST_BFS_EMIT,
        ST_BFS_PICK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic  clear;
        logic  we;
        addr_t waddr;
        row_t  wdata;
        addr_t raddr;
    } adj_cmd_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic addr_t lowest_bit(row_t r);
        addr_t idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (r[i])
            begin
                idx = addr_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/gdt_ifs.sv]
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on gdt_pkg for the field types.
interface gdt_req_if;
    logic          valid;
    logic          ready;
    logic [1:0]    req_type;
    gdt_pkg::vtx_t vertex_a;
    gdt_pkg::vtx_t vertex_b;
    modport source (output valid, req_type, vertex_a, vertex_b, input ready);
    modport sink   (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

interface gdt_res_if;
    logic          valid;
    logic          ready;
    gdt_pkg::vtx_t visited_vertex;
    logic          run_status;
    logic          last_visit;
    modport source (output valid, visited_vertex, run_status, last_visit, input ready);
    modport sink   (input valid, visited_vertex, run_status, last_visit, output ready);
endinterface

interface gdt_cfg_if;
    logic          valid;
    logic          ready;
    gdt_pkg::vtx_t data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/gdt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/core/gdt_adj.sv]
// Adjacency matrix store: one RAM row per vertex plus a valid bit per row.
// A row whose valid bit is clear reads as all zero. Depends on gdt_pkg, gdt_ram.
module gdt_adj (
    input  logic              clk,
    input  logic              rst_n,
    input  gdt_pkg::adj_cmd_t cmd,
    output gdt_pkg::row_t     rdata
);
    logic [gdt_pkg::MAX_VERTICES-1:0] row_valid_reg;
    logic [gdt_pkg::MAX_VERTICES-1:0] row_valid_next;
    logic                             rvalid_reg;
    gdt_pkg::row_t                    ram_rdata;

    gdt_ram #(
        .WIDTH (gdt_pkg::MAX_VERTICES),
        .DEPTH (gdt_pkg::MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (cmd.waddr),
        .wdata (cmd.wdata),
        .raddr (cmd.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (cmd.clear)
        begin
            row_valid_next = '0;
        end
        else if (cmd.we)
        begin
            row_valid_next[cmd.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rvalid_reg    <= row_valid_reg[cmd.raddr];
        end
    end

    assign rdata = rvalid_reg ? ram_rdata : '0;
endmodule

[rtl/core/graph_dfs_bfs_traversal.sv]
// Depth-first / breadth-first traversal over an adjacency matrix held in RAM.
// An edge add reads row a, writes row a while reading row b, then writes row b; a clear
// is applied in idle. An error result goes out through the flush state. A DFS stack step
// is a stack read, a row read and a pick; a BFS dequeue is a read, a row read, an emit
// and a pick per newly found neighbor. The DFS pick and BFS emit wait while output is held.
// Reset clears the row valid bits at once, so the graph is empty with no sweep.
module graph_dfs_bfs_traversal (
    input  logic       clk,
    input  logic       rst_n,
    gdt_req_if.sink    req,
    gdt_res_if.source  res,
    gdt_cfg_if.sink    cfg
);
    gdt_pkg::state_t state_reg, state_next;
    gdt_pkg::vtx_t   vc_reg;
    gdt_pkg::row_t   visited_reg, visited_next;
    gdt_pkg::vtx_t   sp_reg, sp_next, head_reg, head_next, tail_reg, tail_next;
    gdt_pkg::vtx_t   cnt_reg, cnt_next, u_reg, u_next;
    gdt_pkg::vtx_t   a_reg, a_next, b_reg, b_next;
    logic            pend_valid_reg, pend_valid_next;
    gdt_pkg::vtx_t   pend_vertex_reg, pend_vertex_next;
    logic            pend_status_reg, pend_status_next;
    logic            out_valid_reg, out_valid_next;
    gdt_pkg::vtx_t   out_vertex_reg, out_vertex_next;
    logic            out_status_reg, out_status_next, out_last_reg, out_last_next;

    gdt_pkg::adj_cmd_t adj_cmd;
    gdt_pkg::row_t     adj_rdata;
    logic              wk_we;
    gdt_pkg::addr_t    wk_waddr, wk_raddr;
    gdt_pkg::vtx_t     wk_wdata, wk_rdata;

    gdt_pkg::vtx_t  n_act;
    gdt_pkg::row_t  mask, cand;
    gdt_pkg::vtx_t  w_vtx;
    logic           a_ok, b_ok, can_load, can_emit, emit;
    gdt_pkg::vtx_t  emit_vertex;

    gdt_adj u_adj (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (adj_cmd),
        .rdata (adj_rdata)
    );

    // Shared by the DFS stack and the BFS queue; only one run is active at a time.
    gdt_ram #(
        .WIDTH (gdt_pkg::VW),
        .DEPTH (gdt_pkg::MAX_VERTICES)
    ) u_work (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    assign n_act = (vc_reg > gdt_pkg::VW'(gdt_pkg::MAX_VERTICES))
                 ? gdt_pkg::VW'(gdt_pkg::MAX_VERTICES) : vc_reg;

    always_comb
    begin
        for (int i = 0; i < gdt_pkg::MAX_VERTICES; i++) begin
            mask[i] = (gdt_pkg::VW'(i) < n_act);
        end
    end

    assign cand     = adj_rdata & ~visited_reg & mask;
    assign w_vtx    = gdt_pkg::VW'(gdt_pkg::lowest_bit(cand)) + gdt_pkg::VW'(1);
    assign a_ok     = (req.vertex_a != '0) && (req.vertex_a <= n_act);
    assign b_ok     = (req.vertex_b != '0) && (req.vertex_b <= n_act);
    assign can_load = !out_valid_reg || res.ready;
    assign can_emit = !pend_valid_reg || can_load;

    assign req.ready = (state_reg == gdt_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign res.valid          = out_valid_reg;
    assign res.visited_vertex = out_vertex_reg;
    assign res.run_status     = out_status_reg;
    assign res.last_visit     = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        visited_next     = visited_reg;
        sp_next          = sp_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cnt_next         = cnt_reg;
        u_next           = u_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        pend_valid_next  = pend_valid_reg;
        pend_vertex_next = pend_vertex_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_vertex_next  = out_vertex_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        emit             = 1'b0;
        emit_vertex      = u_reg;
        adj_cmd.clear    = 1'b0;
        adj_cmd.we       = 1'b0;
        adj_cmd.waddr    = gdt_pkg::AW'(a_reg - gdt_pkg::VW'(1));
        adj_cmd.wdata    = adj_rdata;
        adj_cmd.raddr    = gdt_pkg::AW'(u_reg - gdt_pkg::VW'(1));
        wk_we            = 1'b0;
        wk_waddr         = '0;
        wk_wdata         = req.vertex_a;
        wk_raddr         = head_reg[gdt_pkg::AW-1:0];

        unique case (state_reg)
            gdt_pkg::ST_IDLE:
            begin
                adj_cmd.raddr = gdt_pkg::AW'(req.vertex_a - gdt_pkg::VW'(1));
                a_next = req.vertex_a;
                b_next = req.vertex_b;
                if (req.valid)
                begin
                    unique case (gdt_pkg::req_t'(req.req_type))
                        gdt_pkg::REQ_EDGE:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_next = gdt_pkg::ST_EDGE_A;
                            end
                        end
                        gdt_pkg::REQ_CLEAR:
                        begin
                            adj_cmd.clear = 1'b1;
                        end
                        gdt_pkg::REQ_DFS, gdt_pkg::REQ_BFS:
                        begin
                            if (!a_ok)
                            begin
                                pend_valid_next  = 1'b1;
                                pend_vertex_next = '0;
                                pend_status_next = 1'b1;
                                state_next       = gdt_pkg::ST_FLUSH;
                            end
                            else
                            begin
                                visited_next = gdt_pkg::row_t'(1)
                                    << gdt_pkg::AW'(req.vertex_a - gdt_pkg::VW'(1));
                                wk_we     = 1'b1;
                                wk_waddr  = '0;
                                if (req.req_type == gdt_pkg::REQ_DFS)
                                begin
                                    emit        = 1'b1;
                                    emit_vertex = req.vertex_a;
                                    sp_next     = gdt_pkg::VW'(1);
                                    cnt_next    = gdt_pkg::VW'(1);
                                    state_next  = gdt_pkg::ST_DFS_RD;
                                end
                                else
                                begin
                                    head_next  = '0;
                                    tail_next  = gdt_pkg::VW'(1);
                                    cnt_next   = '0;
                                    state_next = gdt_pkg::ST_BFS_RD;
                                end
                            end
                        end
                    endcase
                end
            end
            gdt_pkg::ST_EDGE_A:
            begin
                adj_cmd.we    = 1'b1;
                adj_cmd.waddr = gdt_pkg::AW'(a_reg - gdt_pkg::VW'(1));
                adj_cmd.wdata = adj_rdata
                              | (gdt_pkg::row_t'(1) << gdt_pkg::AW'(b_reg - gdt_pkg::VW'(1)));
                adj_cmd.raddr = gdt_pkg::AW'(b_reg - gdt_pkg::VW'(1));
                state_next    = gdt_pkg::ST_EDGE_B;
            end
            gdt_pkg::ST_EDGE_B:
            begin
                adj_cmd.we    = 1'b1;
                adj_cmd.waddr = gdt_pkg::AW'(b_reg - gdt_pkg::VW'(1));
                adj_cmd.wdata = adj_rdata
                              | (gdt_pkg::row_t'(1) << gdt_pkg::AW'(a_reg - gdt_pkg::VW'(1)));
                state_next    = gdt_pkg::ST_IDLE;
            end
            gdt_pkg::ST_DFS_RD:
            begin
                wk_raddr = gdt_pkg::AW'(sp_reg - gdt_pkg::VW'(1));
                if ((sp_reg == '0) || (cnt_reg == gdt_pkg::VW'(gdt_pkg::MAX_VERTICES)))
                begin
                    state_next = gdt_pkg::ST_FLUSH;
                end
                else
                begin
                    state_next = gdt_pkg::ST_DFS_ROW;
                end
            end
            gdt_pkg::ST_DFS_ROW:
            begin
                u_next        = wk_rdata;
                adj_cmd.raddr = gdt_pkg::AW'(wk_rdata - gdt_pkg::VW'(1));
                state_next    = gdt_pkg::ST_DFS_PICK;
            end
            gdt_pkg::ST_DFS_PICK:
            begin
                if (cand == '0)
                begin
                    sp_next    = sp_reg - gdt_pkg::VW'(1);
                    state_next = gdt_pkg::ST_DFS_RD;
                end
                else if (can_emit)
                begin
                    visited_next = visited_reg
                                 | (gdt_pkg::row_t'(1) << gdt_pkg::lowest_bit(cand));
                    emit         = 1'b1;
                    emit_vertex  = w_vtx;
                    cnt_next     = cnt_reg + gdt_pkg::VW'(1);
                    if (sp_reg < gdt_pkg::VW'(gdt_pkg::MAX_VERTICES))
                    begin
                        wk_we    = 1'b1;
                        wk_waddr = sp_reg[gdt_pkg::AW-1:0];
                        wk_wdata = w_vtx;
                        sp_next  = sp_reg + gdt_pkg::VW'(1);
                    end
                    state_next = gdt_pkg::ST_DFS_RD;
                end
            end
            gdt_pkg::ST_BFS_RD:
            begin
                if ((head_reg == tail_reg) || (cnt_reg == gdt_pkg::VW'(gdt_pkg::MAX_VERTICES)))
                begin
                    state_next = gdt_pkg::ST_FLUSH;
                end
                else
                begin
                    state_next = gdt_pkg::ST_BFS_ROW;
                end
            end
            gdt_pkg::ST_BFS_ROW:
            begin
                u_next        = wk_rdata;
                adj_cmd.raddr = gdt_pkg::AW'(wk_rdata - gdt_pkg::VW'(1));
                head_next     = head_reg + gdt_pkg::VW'(1);
                state_next    = gdt_pkg::ST_BFS_EMIT;
            end
            gdt_pkg::ST_BFS_EMIT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    cnt_next   = cnt_reg + gdt_pkg::VW'(1);
                    state_next = gdt_pkg::ST_BFS_PICK;
                end
            end
            gdt_pkg::ST_BFS_PICK:
            begin
                // One newly found neighbor is marked and queued per cycle.
                if (cand == '0)
                begin
                    state_next = gdt_pkg::ST_BFS_RD;
                end
                else
                begin
                    visited_next = visited_reg
                                 | (gdt_pkg::row_t'(1) << gdt_pkg::lowest_bit(cand));
                    if (tail_reg < gdt_pkg::VW'(gdt_pkg::MAX_VERTICES))
                    begin
                        wk_we     = 1'b1;
                        wk_waddr  = tail_reg[gdt_pkg::AW-1:0];
                        wk_wdata  = w_vtx;
                        tail_next = tail_reg + gdt_pkg::VW'(1);
                    end
                end
            end
            gdt_pkg::ST_FLUSH:
            begin
                // The held-back result is the final one of the run.
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = pend_vertex_reg;
                    out_status_next = pend_status_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = gdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdt_pkg::ST_IDLE;
            end
        endcase

        // Each result is held back one step so that the last one can be flagged.
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_vertex_next = pend_vertex_reg;
                out_status_next = pend_status_reg;
                out_last_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_vertex_next = emit_vertex;
            pend_status_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gdt_pkg::ST_IDLE;
            vc_reg         <= gdt_pkg::VW'(gdt_pkg::MAX_VERTICES);
            visited_reg    <= '0;
            sp_reg         <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            visited_reg    <= visited_next;
            sp_reg         <= sp_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                vc_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg           <= u_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        pend_vertex_reg <= pend_vertex_next;
        pend_status_reg <= pend_status_next;
        out_vertex_reg  <= out_vertex_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.run_status |-> res.last_visit && (res.visited_vertex == '0))
        else $error("error result must be a lone final result with vertex zero");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= gdt_pkg::VW'(gdt_pkg::MAX_VERTICES)))
        else $error("queue head passed tail or tail overran");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg <= gdt_pkg::VW'(gdt_pkg::MAX_VERTICES))
        && (cnt_reg <= gdt_pkg::VW'(gdt_pkg::MAX_VERTICES)))
        else $error("stack pointer or result count out of range");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdt_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("held-back result left over after a run");
endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the graph traversal block: add-edge, clear and
// search items in, visit order out, compared with a predictor of the search.
// Depends on gdt_pkg, the gdt_*_if channel interfaces and the block itself.
module testbench;

    typedef struct {
        gdt_pkg::vtx_t vertex;
        logic          status;
        logic          last;
    } visit_t;

    // Keeps its own copy of the graph and the vertex count, and turns each
    // accepted request into the visits the block should produce.
    class visit_scoreboard;
        bit [63:0]  adj_rows [64];
        bit [6:0]   vertex_count;
        visit_t     visits_due [$];
        int         errors;
        int         checked;
        int         searches;

        function new();
            vertex_count = 7'd64;
            foreach (adj_rows[i])
            begin
                adj_rows[i] = '0;
            end
        endfunction

        function void note_request(gdt_pkg::req_t kind, bit [6:0] a, bit [6:0] b);
            int        n;
            bit [63:0] seen;
            int        order [$];
            int        pending [$];
            int        u;
            int        w;
            visit_t    v;
            n = (vertex_count > 64) ? 64 : vertex_count;
            seen = '0;
            case (kind)
                gdt_pkg::REQ_EDGE:
                begin
                    if (a >= 1 && a <= n && b >= 1 && b <= n)
                    begin
                        adj_rows[a - 1][b - 1] = 1'b1;
                        adj_rows[b - 1][a - 1] = 1'b1;
                    end
                    return;
                end
                gdt_pkg::REQ_CLEAR:
                begin
                    foreach (adj_rows[i])
                    begin
                        adj_rows[i] = '0;
                    end
                    return;
                end
                default:
                begin
                end
            endcase
            searches++;
            if (a < 1 || a > n)
            begin
                v.vertex = '0;
                v.status = 1'b1;
                v.last = 1'b1;
                visits_due = {visits_due, v};
                return;
            end
            seen[a - 1] = 1'b1;
            pending = {pending, int'(a)};
            if (kind == gdt_pkg::REQ_DFS)
            begin
                order = {order, int'(a)};
                while (pending.size() > 0 && order.size() < 64)
                begin
                    u = pending[$];
                    w = 0;
                    for (int k = 1; k <= n && w == 0; k++)
                    begin
                        if (adj_rows[u - 1][k - 1] && !seen[k - 1])
                        begin
                            w = k;
                        end
                    end
                    if (w != 0)
                    begin
                        seen[w - 1] = 1'b1;
                        order = {order, w};
                        pending = {pending, w};
                    end
                    else
                    begin
                        void'(pending.pop_back());
                    end
                end
            end
            else
            begin
                // Breadth-first marks a vertex when it is queued.
                while (pending.size() > 0 && order.size() < 64)
                begin
                    u = pending[0];
                    pending.delete(0);
                    order = {order, u};
                    for (int k = 1; k <= n; k++)
                    begin
                        if (adj_rows[u - 1][k - 1] && !seen[k - 1])
                        begin
                            seen[k - 1] = 1'b1;
                            pending = {pending, k};
                        end
                    end
                end
            end
            foreach (order[i])
            begin
                v.vertex = gdt_pkg::vtx_t'(order[i]);
                v.status = 1'b0;
                v.last = (i == order.size() - 1);
                visits_due = {visits_due, v};
            end
        endfunction

        function void check_visit(gdt_pkg::vtx_t vertex, logic status, logic last);
            visit_t e;
            checked++;
            if (visits_due.size() == 0)
            begin
                $display("%0t: unexpected result vertex=%0d status=%0d last=%0d",
                         $time, vertex, status, last);
                errors++;
                return;
            end
            e = visits_due[0];
            visits_due.delete(0);
            if (vertex !== e.vertex || status !== e.status || last !== e.last)
            begin
                $display("%0t: mismatch expected vertex=%0d status=%0d last=%0d,",
                         $time, e.vertex, e.status, e.last);
                $display("    got vertex=%0d status=%0d last=%0d", vertex, status, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gdt_req_if rq ();
    gdt_res_if rs ();
    gdt_cfg_if cf ();

    graph_dfs_bfs_traversal dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rq),
        .res   (rs),
        .cfg   (cf)
    );

    visit_scoreboard sb = new();
    bit  no_idle = 1'b0;
    bit  hold_long = 1'b0;
    int  sent_items = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;

    localparam int QUIET_LIMIT = 6000;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        rq.valid = 1'b0;
        rq.req_type = '0;
        rq.vertex_a = '0;
        rq.vertex_b = '0;
        cf.valid = 1'b0;
        cf.data = '0;
        rs.ready = 1'b0;
    end

    // Result side: check on acceptance, then pick next ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rs.valid && rs.ready)
            begin
                sb.check_visit(rs.visited_vertex, rs.run_status, rs.last_visit);
            end
            if (hold_long)
            begin
                hold_long <= 1'b0;
                hold_left <= 400;
                rs.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rs.ready <= (hold_left == 1);
            end
            else
            begin
                rs.ready <= no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rq.valid && rq.ready) || (rs.valid && rs.ready) || (cf.valid && cf.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(gdt_pkg::req_t kind, bit [6:0] a, bit [6:0] b);
        if (!no_idle && $urandom_range(99) < 17)
        begin
            rq.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        rq.valid <= 1'b1;
        rq.req_type <= kind;
        rq.vertex_a <= a;
        rq.vertex_b <= b;
        do
            @(posedge clk);
        while (!rq.ready);
        sb.note_request(kind, a, b);
        sent_items++;
    endtask

    // Waits until every expected visit has come, then lets an edge or clear
    // item that is still being applied finish.
    task automatic drain_results();
        rq.valid <= 1'b0;
        @(posedge clk);
        while (sb.visits_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_vertex_count(bit [6:0] value);
        drain_results();
        cf.valid <= 1'b1;
        cf.data <= value;
        do
            @(posedge clk);
        while (!cf.ready);
        cf.valid <= 1'b0;
        sb.vertex_count = value;
    endtask

    task automatic send_random(int n);
        int roll;
        bit [6:0] a;
        bit [6:0] b;
        int top;
        top = (n < 1) ? 1 : n;
        roll = $urandom_range(99);
        a = 7'($urandom_range(1, top));
        b = 7'($urandom_range(1, top));
        if (roll < 45)
        begin
            send_request(gdt_pkg::REQ_EDGE, a, b);
        end
        else if (roll < 52)
        begin
            send_request(gdt_pkg::REQ_EDGE, 7'($urandom_range(127)), 7'($urandom_range(127)));
        end
        else if (roll < 70)
        begin
            send_request(gdt_pkg::REQ_DFS, a, 7'($urandom_range(127)));
        end
        else if (roll < 88)
        begin
            send_request(gdt_pkg::REQ_BFS, a, 7'($urandom_range(127)));
        end
        else if (roll < 95)
        begin
            send_request(($urandom_range(1) != 0) ? gdt_pkg::REQ_DFS : gdt_pkg::REQ_BFS,
                         7'($urandom_range(127)), b);
        end
        else
        begin
            send_request(gdt_pkg::REQ_CLEAR, 7'($urandom_range(127)),
                         7'($urandom_range(127)));
        end
    endtask

    initial
    begin
        bit [6:0] counts [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd12, 7'd5, 7'd64};
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, self loop, ignored edges, bad starts, clear.
        send_request(gdt_pkg::REQ_DFS, 7'd1, 7'd0);
        send_request(gdt_pkg::REQ_EDGE, 7'd1, 7'd64);
        send_request(gdt_pkg::REQ_EDGE, 7'd64, 7'd2);
        send_request(gdt_pkg::REQ_EDGE, 7'd2, 7'd3);
        send_request(gdt_pkg::REQ_EDGE, 7'd1, 7'd5);
        send_request(gdt_pkg::REQ_EDGE, 7'd5, 7'd5);
        send_request(gdt_pkg::REQ_EDGE, 7'd0, 7'd3);
        send_request(gdt_pkg::REQ_EDGE, 7'd3, 7'd65);
        send_request(gdt_pkg::REQ_EDGE, 7'd127, 7'd127);
        send_request(gdt_pkg::REQ_DFS, 7'd1, 7'd127);
        send_request(gdt_pkg::REQ_BFS, 7'd1, 7'd0);
        send_request(gdt_pkg::REQ_BFS, 7'd64, 7'd0);
        send_request(gdt_pkg::REQ_DFS, 7'd5, 7'd0);
        send_request(gdt_pkg::REQ_DFS, 7'd0, 7'd0);
        send_request(gdt_pkg::REQ_BFS, 7'd65, 7'd0);
        send_request(gdt_pkg::REQ_DFS, 7'd127, 7'd0);
        for (int i = 1; i < 64; i++)
        begin
            if (i == 1)
            begin
                send_request(gdt_pkg::REQ_CLEAR, 7'd0, 7'd0);
            end
            send_request(gdt_pkg::REQ_EDGE, 7'(i), 7'(i + 1));
        end
        send_request(gdt_pkg::REQ_DFS, 7'd1, 7'd0);
        send_request(gdt_pkg::REQ_BFS, 7'd32, 7'd0);
        send_request(gdt_pkg::REQ_DFS, 7'd64, 7'd0);

        foreach (counts[p])
        begin
            write_vertex_count(counts[p]);
            n = (counts[p] > 64) ? 64 : counts[p];
            if (p == 2)
            begin
                hold_long = 1'b1;
            end
            no_idle = (p == 3);
            for (int i = 0; i < 18; i++)
            begin
                if (p == 5 && i == 11)
                begin
                    drain_results();
                end
                send_random(n);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (50) @(posedge clk);
        $display("Sent %0d requests including %0d searches; checked %0d visits",
                 sent_items, sb.searches, sb.checked);
        $display("Vertex counts swept from 0 to 127, with long output stalls and drains");
        if (sb.errors == 0 && sb.visits_due.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
